// ===== hw/rtl/mkdt_pkg.sv =====
// ----------------------------------------------------------------------------
// mkdt_pkg
// Shared types and constants for the keyed device table: command and status
// codes, the request broadcast to every cell and the token that walks the chain.
// ----------------------------------------------------------------------------
package mkdt_pkg;

	localparam int TABLE_ENTRIES_DEF = 40;

	localparam int CMD_W    = 2;
	localparam int MAC_W    = 48;
	localparam int RSSI_W   = 8;
	localparam int SEEN_W   = 32;
	localparam int SER_W    = 64;
	localparam int STATUS_W = 3;
	localparam int SLOT_W   = 6;

	typedef enum logic [CMD_W-1:0] {
		CMD_UPSERT = 2'd0,
		CMD_STORE  = 2'd1,
		CMD_LOOKUP = 2'd2
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_UPDATED   = 3'd0,
		STAT_INSERTED  = 3'd1,
		STAT_FULL      = 3'd2,
		STAT_STORED    = 3'd3,
		STAT_KEPT      = 3'd4,
		STAT_NOT_FOUND = 3'd5,
		STAT_FOUND     = 3'd6
	} status_t;

	// request held at the top while a token walks the chain
	typedef struct packed {
		cmd_t                     cmd;
		logic [MAC_W-1:0]         mac;
		logic signed [RSSI_W-1:0] rssi;
		logic [SEEN_W-1:0]        seen;
		logic [SER_W-1:0]         ser_lo;   // already trimmed after first NUL
		logic [SER_W-1:0]         ser_hi;
		logic                     ser_empty;
	} req_t;

	// token handed from cell to cell; carries the result once resolved
	typedef struct packed {
		logic              live;
		logic              done;
		status_t           status;
		logic [SLOT_W-1:0] slot;
		logic [SER_W-1:0]  flo;
		logic [SER_W-1:0]  fhi;
	} tok_t;

endpackage

// ===== hw/rtl/mkdt_cell.sv =====
// ----------------------------------------------------------------------------
// mkdt_cell
// One table entry. Resolves the passing token on an address match or at the
// first unused entry, otherwise hands it on unchanged in the next cycle.
// ----------------------------------------------------------------------------
module mkdt_cell #(
	parameter int CELL_ID = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  mkdt_pkg::req_t req,
	input  mkdt_pkg::tok_t tok_in,
	output mkdt_pkg::tok_t tok_out
);

	localparam logic [mkdt_pkg::SLOT_W-1:0] CELL_SLOT = CELL_ID[mkdt_pkg::SLOT_W-1:0];

	logic                              used_q;
	logic                              has_serial_q;
	logic [mkdt_pkg::MAC_W-1:0]        addr_q;
	logic signed [mkdt_pkg::RSSI_W-1:0] strength_q;
	logic [mkdt_pkg::SEEN_W-1:0]       seen_q;
	logic [mkdt_pkg::SER_W-1:0]        ser_lo_q;
	logic [mkdt_pkg::SER_W-1:0]        ser_hi_q;
	mkdt_pkg::tok_t                    tok_q;
	mkdt_pkg::tok_t                    tok_n;

	logic wr_new;
	logic wr_sight;
	logic wr_serial;

	// Entries fill lowest first and are never freed, so the first unused
	// entry ends the search: no match can sit beyond it.
	always_comb begin
		tok_n     = tok_in;
		wr_new    = 1'b0;
		wr_sight  = 1'b0;
		wr_serial = 1'b0;
		if (tok_in.live && !tok_in.done) begin
			if (!used_q) begin
				tok_n.done = 1'b1;
				if (req.cmd == mkdt_pkg::CMD_UPSERT) begin
					wr_new       = 1'b1;
					tok_n.status = mkdt_pkg::STAT_INSERTED;
					tok_n.slot   = CELL_SLOT;
				end else begin
					tok_n.status = mkdt_pkg::STAT_NOT_FOUND;
				end
			end else if (addr_q == req.mac) begin
				tok_n.done = 1'b1;
				case (req.cmd)
					mkdt_pkg::CMD_UPSERT: begin
						wr_sight     = 1'b1;
						tok_n.status = mkdt_pkg::STAT_UPDATED;
						tok_n.slot   = CELL_SLOT;
					end
					mkdt_pkg::CMD_STORE: begin
						tok_n.slot = CELL_SLOT;
						if (!has_serial_q && !req.ser_empty) begin
							wr_serial    = 1'b1;
							tok_n.status = mkdt_pkg::STAT_STORED;
						end else begin
							tok_n.status = mkdt_pkg::STAT_KEPT;
						end
					end
					mkdt_pkg::CMD_LOOKUP: begin
						if (has_serial_q) begin
							tok_n.status = mkdt_pkg::STAT_FOUND;
							tok_n.slot   = CELL_SLOT;
							tok_n.flo    = ser_lo_q;
							tok_n.fhi    = ser_hi_q;
						end else begin
							tok_n.status = mkdt_pkg::STAT_NOT_FOUND;
						end
					end
					default: begin
						tok_n.status = mkdt_pkg::STAT_NOT_FOUND;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q       <= 1'b0;
			has_serial_q <= 1'b0;
			tok_q        <= '0;
		end else begin
			tok_q <= tok_n;
			if (wr_new) begin
				used_q       <= 1'b1;
				has_serial_q <= 1'b0;
			end
			if (wr_serial) begin
				has_serial_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_new) begin
			addr_q <= req.mac;
		end
		if (wr_new || wr_sight) begin
			strength_q <= req.rssi;
			seen_q     <= req.seen;
		end
		if (wr_serial) begin
			ser_lo_q <= req.ser_lo;
			ser_hi_q <= req.ser_hi;
		end
	end

	assign tok_out = tok_q;

endmodule

// ===== hw/rtl/mac_keyed_device_table_unit.sv =====
// ----------------------------------------------------------------------------
// mac_keyed_device_table_unit
// Device table keyed by 48-bit address: upsert sightings, store a serial
// once, look up a serial. One cell per entry; a token walks the cell chain.
// ----------------------------------------------------------------------------
//
//  channel   handshake              payload
//  --------  ---------------------  ----------------------------------------
//  in        in_valid / in_ready    command mac rssi seen_seconds
//                                   serial_lo serial_hi
//  out       out_valid / out_ready  status slot found_serial_lo found_serial_hi
//
//  A request runs from acceptance to result through a launch register and
//  then the whole chain: the token moves one cell per cycle. A new request
//  is taken only after the last one's result has gone to the output register.
//  Reset clears every entry at once (used and serial-held flags).
//  A stalled result waits in the output register while the next request
//  runs; a second result then parks in a holding register until taken.
// ----------------------------------------------------------------------------
module mac_keyed_device_table_unit #(
	parameter int TABLE_ENTRIES = mkdt_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [mkdt_pkg::CMD_W-1:0]          command,
	input  logic [mkdt_pkg::MAC_W-1:0]          mac,
	input  logic signed [mkdt_pkg::RSSI_W-1:0]  rssi,
	input  logic [mkdt_pkg::SEEN_W-1:0]         seen_seconds,
	input  logic [mkdt_pkg::SER_W-1:0]          serial_lo,
	input  logic [mkdt_pkg::SER_W-1:0]          serial_hi,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [mkdt_pkg::STATUS_W-1:0]       status,
	output logic [mkdt_pkg::SLOT_W-1:0]         slot,
	output logic [mkdt_pkg::SER_W-1:0]          found_serial_lo,
	output logic [mkdt_pkg::SER_W-1:0]          found_serial_hi
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_RUN  = 3'b010,
		S_HOLD = 3'b100
	} state_t;

	// zero every character after the first NUL of the 16
	function automatic logic [2*mkdt_pkg::SER_W-1:0] trim_serial(
		input logic [2*mkdt_pkg::SER_W-1:0] s
	);
		logic                         ended;
		logic [2*mkdt_pkg::SER_W-1:0] r;
		ended = 1'b0;
		r     = s;
		for (int k = 0; k < 16; k++) begin
			if (ended) begin
				r[k*8 +: 8] = 8'h00;
			end else if (s[k*8 +: 8] == 8'h00) begin
				ended = 1'b1;
			end
		end
		return r;
	endfunction

	state_t                        state_q;
	mkdt_pkg::req_t                req_q;
	mkdt_pkg::tok_t                tok0_q;
	mkdt_pkg::tok_t                pend_q;
	mkdt_pkg::tok_t                out_q;
	logic                          out_valid_q;
	mkdt_pkg::tok_t                tok [TABLE_ENTRIES+1];
	logic [TABLE_ENTRIES:0]        live_vec;
	logic [2*mkdt_pkg::SER_W-1:0]  ser_trim;
	logic                          in_fire;
	logic                          out_free;
	logic                          load_out;
	mkdt_pkg::tok_t                tok_end;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign load_out = (state_q == S_RUN && tok_end.live && out_free) ||
	                  (state_q == S_HOLD && out_ready);
	assign ser_trim = trim_serial({serial_hi, serial_lo});
	assign tok[0]   = tok0_q;
	assign tok_end  = tok[TABLE_ENTRIES];

	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		mkdt_cell #(
			.CELL_ID(i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.req    (req_q),
			.tok_in (tok[i]),
			.tok_out(tok[i+1])
		);
	end

	for (genvar i = 0; i <= TABLE_ENTRIES; i++) begin : g_live
		assign live_vec[i] = tok[i].live;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			tok0_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= load_out || (out_valid_q && !out_ready);
			tok0_q.live <= in_fire;
			if (in_fire) begin
				// default outcome if no cell resolves the token
				tok0_q.done   <= 1'b0;
				tok0_q.status <= (mkdt_pkg::cmd_t'(command) == mkdt_pkg::CMD_UPSERT) ?
				                 mkdt_pkg::STAT_FULL : mkdt_pkg::STAT_NOT_FOUND;
				tok0_q.slot   <= '0;
				tok0_q.flo    <= '0;
				tok0_q.fhi    <= '0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					if (tok_end.live) begin
						if (out_free) begin
							state_q <= S_IDLE;
						end else begin
							state_q <= S_HOLD;
						end
					end
				end
				S_HOLD: begin
					if (out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_q.cmd       <= mkdt_pkg::cmd_t'(command);
			req_q.mac       <= mac;
			req_q.rssi      <= rssi;
			req_q.seen      <= seen_seconds;
			req_q.ser_lo    <= ser_trim[mkdt_pkg::SER_W-1:0];
			req_q.ser_hi    <= ser_trim[2*mkdt_pkg::SER_W-1:mkdt_pkg::SER_W];
			req_q.ser_empty <= (serial_lo[7:0] == 8'h00);
		end
		if (state_q == S_RUN && tok_end.live) begin
			if (out_free) begin
				out_q <= tok_end;
			end else begin
				pend_q <= tok_end;
			end
		end
		if (state_q == S_HOLD && out_ready) begin
			out_q <= pend_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = out_q.status;
	assign slot            = out_q.slot;
	assign found_serial_lo = out_q.flo;
	assign found_serial_hi = out_q.fhi;

`ifndef NO_ASSERTIONS
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(live_vec))
		else $error("more than one request token in the chain");

	a_end_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		tok_end.live |-> (state_q == S_RUN))
		else $error("token left the chain outside of a run");

	a_hold_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_HOLD) |-> out_valid_q)
		else $error("result parked while output register empty");

	a_run_resolves: assert property (@(posedge clk) disable iff (!arst_n)
		tok_end.live |-> (tok_end.done || tok_end.status == mkdt_pkg::STAT_FULL ||
		                  tok_end.status == mkdt_pkg::STAT_NOT_FOUND))
		else $error("unresolved token carries a resolved status");
`endif

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the keyed device table. It drives requests for
// upsert, store-serial, lookup and the reserved code against a mirror of the
// table kept in the bench, with random idling on both channels and one long
// output stall. Every result is checked against the mirror, oldest request first.
// ----------------------------------------------------------------------------
module testbench;
	import mkdt_pkg::*;

	localparam int ENTRIES = TABLE_ENTRIES_DEF;
	localparam int REQ_LATENCY = ENTRIES + 2;
	localparam int POOL_SIZE = 64;
	localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

	typedef struct {
		logic [CMD_W-1:0]         command;
		logic [MAC_W-1:0]         mac;
		logic signed [RSSI_W-1:0] rssi;
		logic [SEEN_W-1:0]        seen;
		logic [SER_W-1:0]         ser_lo;
		logic [SER_W-1:0]         ser_hi;
	} dev_req_t;

	typedef struct packed {
		status_t           status;
		logic [SLOT_W-1:0] slot;
		logic [SER_W-1:0]  flo;
		logic [SER_W-1:0]  fhi;
	} dev_resp_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [CMD_W-1:0] command;
	logic [MAC_W-1:0] mac;
	logic signed [RSSI_W-1:0] rssi;
	logic [SEEN_W-1:0] seen_seconds;
	logic [SER_W-1:0] serial_lo;
	logic [SER_W-1:0] serial_hi;
	logic out_valid;
	logic out_ready;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0] slot;
	logic [SER_W-1:0] found_serial_lo;
	logic [SER_W-1:0] found_serial_hi;

	// mirror of the device table
	bit                tbl_used [ENTRIES];
	logic [MAC_W-1:0]  tbl_mac [ENTRIES];
	logic [RSSI_W-1:0] tbl_rssi [ENTRIES];
	logic [SEEN_W-1:0] tbl_seen [ENTRIES];
	bit                tbl_has_ser [ENTRIES];
	logic [SER_W-1:0]  tbl_ser_lo [ENTRIES];
	logic [SER_W-1:0]  tbl_ser_hi [ENTRIES];

	dev_resp_t expected_q[$];
	dev_resp_t got_resp;
	dev_resp_t want_resp;
	logic [MAC_W-1:0] mac_pool [POOL_SIZE];

	int errors = 0;
	int sent = 0;
	int received = 0;
	int status_count [8];

	bit idle_on = 1'b1;
	bit hold_req = 1'b0;
	bit hold_active = 1'b0;
	int hold_len = 0;

	mac_keyed_device_table_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.command         (command),
		.mac             (mac),
		.rssi            (rssi),
		.seen_seconds    (seen_seconds),
		.serial_lo       (serial_lo),
		.serial_hi       (serial_hi),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.status          (status),
		.slot            (slot),
		.found_serial_lo (found_serial_lo),
		.found_serial_hi (found_serial_hi)
	);

	always #2 clk = ~clk;

	// zero every character after the first NUL, {hi, lo} with char 0 lowest
	function automatic logic [127:0] trim_serial(input logic [SER_W-1:0] lo,
		input logic [SER_W-1:0] hi);
		logic [127:0] s;
		bit ended;
		s = {hi, lo};
		ended = 1'b0;
		for (int k = 0; k < 16; k++) begin
			if (ended)
				s[k*8 +: 8] = 8'h00;
			else if (s[k*8 +: 8] == 8'h00)
				ended = 1'b1;
		end
		return s;
	endfunction

	// apply one request to the mirror and return the result it should give
	function automatic dev_resp_t apply_request(input dev_req_t r);
		dev_resp_t res;
		int hit;
		int free_idx;
		logic [127:0] ser;
		res.status = STAT_NOT_FOUND;
		res.slot = '0;
		res.flo = '0;
		res.fhi = '0;
		hit = -1;
		free_idx = -1;
		for (int i = 0; i < ENTRIES; i++) begin
			if (hit < 0 && tbl_used[i] && tbl_mac[i] == r.mac)
				hit = i;
			if (free_idx < 0 && !tbl_used[i])
				free_idx = i;
		end
		case (r.command)
			CMD_UPSERT: begin
				if (hit >= 0) begin
					tbl_rssi[hit] = r.rssi;
					tbl_seen[hit] = r.seen;
					res.status = STAT_UPDATED;
					res.slot = SLOT_W'(hit);
				end else if (free_idx >= 0) begin
					tbl_used[free_idx] = 1'b1;
					tbl_mac[free_idx] = r.mac;
					tbl_rssi[free_idx] = r.rssi;
					tbl_seen[free_idx] = r.seen;
					tbl_has_ser[free_idx] = 1'b0;
					tbl_ser_lo[free_idx] = '0;
					tbl_ser_hi[free_idx] = '0;
					res.status = STAT_INSERTED;
					res.slot = SLOT_W'(free_idx);
				end else begin
					res.status = STAT_FULL;
				end
			end
			CMD_STORE: begin
				if (hit >= 0) begin
					res.slot = SLOT_W'(hit);
					if (!tbl_has_ser[hit] && r.ser_lo[7:0] != 8'h00) begin
						ser = trim_serial(r.ser_lo, r.ser_hi);
						tbl_ser_lo[hit] = ser[63:0];
						tbl_ser_hi[hit] = ser[127:64];
						tbl_has_ser[hit] = 1'b1;
						res.status = STAT_STORED;
					end else begin
						res.status = STAT_KEPT;
					end
				end
			end
			CMD_LOOKUP: begin
				if (hit >= 0 && tbl_has_ser[hit]) begin
					res.status = STAT_FOUND;
					res.slot = SLOT_W'(hit);
					res.flo = tbl_ser_lo[hit];
					res.fhi = tbl_ser_hi[hit];
				end
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	// mostly printable characters, some high bytes, now and then a NUL
	function automatic logic [127:0] make_serial();
		logic [127:0] s;
		int pos;
		for (int k = 0; k < 16; k++) begin
			if ($urandom_range(0, 9) < 7)
				s[k*8 +: 8] = 8'($urandom_range(8'h20, 8'h7e));
			else
				s[k*8 +: 8] = 8'($urandom_range(1, 255));
		end
		if ($urandom_range(0, 9) == 0) begin
			s[7:0] = 8'h00;
		end else if ($urandom_range(0, 2) == 0) begin
			pos = $urandom_range(1, 15);
			s[pos*8 +: 8] = 8'h00;
		end
		return s;
	endfunction

	function automatic dev_req_t make_request(input logic [CMD_W-1:0] cmd,
		input logic [MAC_W-1:0] addr);
		dev_req_t r;
		logic [127:0] s;
		s = make_serial();
		r.command = cmd;
		r.mac = addr;
		r.rssi = RSSI_W'($urandom);
		r.seen = $urandom;
		r.ser_lo = s[63:0];
		r.ser_hi = s[127:64];
		return r;
	endfunction

	function automatic logic [MAC_W-1:0] random_mac();
		logic [MAC_W-1:0] m;
		m[47:32] = 16'($urandom);
		m[31:0] = $urandom;
		return m;
	endfunction

	// drive one request and hold it until the table takes it
	task automatic send_request(input dev_req_t r);
		dev_resp_t res;
		int gap;
		command <= r.command;
		mac <= r.mac;
		rssi <= r.rssi;
		seen_seconds <= r.seen;
		serial_lo <= r.ser_lo;
		serial_hi <= r.ser_hi;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		res = apply_request(r);
		expected_q.push_back(res);
		status_count[res.status]++;
		sent++;
		gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// mostly upsert/store/lookup runs on known addresses, the rest noise
	task automatic run_random(input int n, input int pool_used, input bit fresh_upsert);
		int count;
		int pick;
		logic [MAC_W-1:0] addr;
		logic [CMD_W-1:0] cmd;
		count = 0;
		while (count < n) begin
			addr = mac_pool[$urandom_range(0, pool_used - 1)];
			if ($urandom_range(0, 9) < 5) begin
				send_request(make_request(CMD_UPSERT, addr));
				send_request(make_request(CMD_STORE, addr));
				send_request(make_request(CMD_LOOKUP, addr));
				count += 3;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 80) begin
					cmd = (pick < 28) ? CMD_UPSERT : (pick < 54) ? CMD_STORE : CMD_LOOKUP;
				end else begin
					addr = random_mac();
					cmd = CMD_W'($urandom_range(fresh_upsert ? 0 : 1, 3));
				end
				send_request(make_request(cmd, addr));
				count++;
			end
		end
	endtask

	task automatic test_directed();
		dev_req_t r;
		r = make_request(CMD_LOOKUP, mac_pool[0]);
		send_request(r);
		r = make_request(CMD_STORE, mac_pool[0]);
		send_request(r);
		r = make_request(CMD_UPSERT, mac_pool[0]);
		r.rssi = -8'sd128;
		r.seen = '0;
		send_request(r);
		r = make_request(CMD_UPSERT, mac_pool[1]);
		r.rssi = 8'sd127;
		r.seen = '1;
		send_request(r);
		r = make_request(CMD_UPSERT, mac_pool[0]);
		send_request(r);
		r = make_request(CMD_LOOKUP, mac_pool[0]);
		send_request(r);
		// empty serial: first character NUL
		r = make_request(CMD_STORE, mac_pool[0]);
		r.ser_lo = 64'hffff_ffff_ffff_ff00;
		r.ser_hi = '1;
		send_request(r);
		r = make_request(CMD_LOOKUP, mac_pool[0]);
		send_request(r);
		// NUL inside the low word, everything after it dropped
		r = make_request(CMD_STORE, mac_pool[0]);
		r.ser_lo = 64'h3837_0035_3433_3231;
		r.ser_hi = 64'h4847_4645_4443_4241;
		send_request(r);
		r = make_request(CMD_LOOKUP, mac_pool[0]);
		send_request(r);
		r = make_request(CMD_STORE, mac_pool[0]);
		r.ser_lo = 64'h5a5a_5a5a_5a5a_5a5a;
		send_request(r);
		r = make_request(CMD_STORE, mac_pool[1]);
		r.ser_lo = '1;
		r.ser_hi = '1;
		send_request(r);
		r = make_request(CMD_LOOKUP, mac_pool[1]);
		send_request(r);
		r = make_request(CMD_RESERVED, mac_pool[0]);
		send_request(r);
		r = make_request(CMD_UPSERT, mac_pool[2]);
		send_request(r);
		// NUL at character 8
		r = make_request(CMD_STORE, mac_pool[2]);
		r.ser_lo = 64'h4847_4645_4443_4241;
		r.ser_hi = 64'h5a59_5857_5655_5400;
		send_request(r);
		r = make_request(CMD_LOOKUP, mac_pool[2]);
		send_request(r);
		r = make_request(CMD_LOOKUP, 48'h1234_5678_9abc);
		send_request(r);
		r = make_request(CMD_RESERVED, 48'h1234_5678_9abc);
		send_request(r);
	endtask

	// table stays below capacity: no upserts of fresh addresses
	task automatic test_random_mixed();
		run_random(400, 30, 1'b0);
	endtask

	// receiver holds off long enough for the table to back up its input
	task automatic test_output_stall();
		in_valid <= 1'b0;
		idle_on = 1'b0;
		hold_len = 600;
		hold_req = 1'b1;
		while (!hold_active) @(posedge clk);
		run_random(10, 40, 1'b0);
		idle_on = 1'b1;
	endtask

	// more addresses than entries: the table fills and drops sightings
	task automatic test_table_full();
		run_random(450, POOL_SIZE, 1'b1);
	endtask

	task automatic test_back_to_back();
		idle_on = 1'b0;
		run_random(250, POOL_SIZE, 1'b1);
	endtask

	// receiver: random ready bursts, plus the requested long hold
	initial begin
		out_ready = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				hold_active = 1'b1;
				repeat (hold_len) @(posedge clk);
				hold_active = 1'b0;
				hold_req = 1'b0;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			received++;
			got_resp.status = status_t'(status);
			got_resp.slot = slot;
			got_resp.flo = found_serial_lo;
			got_resp.fhi = found_serial_hi;
			if (expected_q.size() == 0) begin
				$display("%0t ns: result with no request pending: status %0d slot %0d",
					$time, status, slot);
				errors++;
			end else begin
				want_resp = expected_q.pop_front();
				if (got_resp !== want_resp) begin
					$display("%0t ns: mismatch expected status %0d slot %0d ser %h_%h",
						$time, want_resp.status, want_resp.slot, want_resp.fhi, want_resp.flo);
					$display("%0t ns:          actual   status %0d slot %0d ser %h_%h",
						$time, status, slot, found_serial_hi, found_serial_lo);
					errors++;
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("FAIL mac_keyed_device_table_unit");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = '0;
		mac = '0;
		rssi = '0;
		seen_seconds = '0;
		serial_lo = '0;
		serial_hi = '0;
		for (int i = 0; i < 8; i++)
			status_count[i] = 0;
		for (int i = 0; i < ENTRIES; i++) begin
			tbl_used[i] = 1'b0;
			tbl_has_ser[i] = 1'b0;
		end
		mac_pool[0] = '0;
		mac_pool[1] = '1;
		mac_pool[2] = 48'h8000_0000_0001;
		for (int i = 3; i < POOL_SIZE; i++)
			mac_pool[i] = random_mac();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_mixed();
		test_output_stall();
		test_table_full();
		test_back_to_back();
		in_valid <= 1'b0;

		for (int w = 0; w < 20000 && expected_q.size() != 0; w++)
			@(posedge clk);
		repeat (3 * REQ_LATENCY) @(posedge clk);
		if (expected_q.size() != 0) begin
			$display("%0t ns: %0d results never arrived", $time, expected_q.size());
			errors += expected_q.size();
		end

		$display("Ran %0d requests, %0d results: %0d inserted, %0d updated, %0d dropped full",
			sent, received, status_count[STAT_INSERTED], status_count[STAT_UPDATED],
			status_count[STAT_FULL]);
		$display("Serials stored %0d, kept %0d; lookups hit %0d; misses %0d",
			status_count[STAT_STORED], status_count[STAT_KEPT], status_count[STAT_FOUND],
			status_count[STAT_NOT_FOUND]);
		if (errors == 0)
			$display("PASS mac_keyed_device_table_unit");
		else
			$display("FAIL mac_keyed_device_table_unit");
		$finish;
	end

endmodule
